// ----- hdl/sss_pkg.sv -----
// Shared constants and transaction types of the suffixient set scan block.
package sss_pkg;

	// Fixed field widths
	localparam int CHAR_W = 4;
	localparam int CHAR_N = 2 ** CHAR_W;
	localparam int WORD_W = 32;
	localparam int LEN_W = WORD_W + 1;

	// Defaults for the top-level parameters
	localparam int DEF_ALPHABET_SIZE = 16;
	localparam int DEF_POS_BITS = 32;

	// Most results one row may cause
	localparam int MAX_RESULTS = 17;

	// Reset value of the text length register
	localparam logic [WORD_W-1:0] TEXT_LEN_RESET = 32'd2;

	// One suffix-array row
	typedef struct packed {
		logic [WORD_W-1:0] sa_value;
		logic [WORD_W-1:0] lcp;
		logic [CHAR_W-1:0] bwt_char;
		logic              is_last;
	} row_t;

	// One suffixient entry
	typedef struct packed {
		logic [WORD_W-1:0] entry_index;
		logic [WORD_W-1:0] text_position;
		logic [WORD_W-1:0] lcs_value;
		logic [CHAR_W-1:0] entry_char;
		logic              has_prev;
		logic [WORD_W-1:0] prev_index;
		logic [WORD_W-1:0] prev_lcs;
		logic              last_of_run;
	} entry_t;

endpackage

// ----- hdl/sss_chan_if.sv -----
// Valid/ready channel carrying one payload per transaction.
interface sss_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/suffixient_set_scan_top.sv -----
// Suffixient set scan: takes suffix-array rows (SA value, LCP, BWT character, last mark) one
// transaction at a time and emits suffixient entries on the entries channel. A row without a
// BWT character change, unless marked last, needs no scan. A row with a change runs one
// sequential scan over the per-character candidates, one character per cycle unless stalled,
// through a single shared 33-bit compare and update path: the accept, characters 1 and up in
// order, a refresh step and a finish step. A row marked last runs a further scan over the same
// characters for the final flush. The rows channel is not ready while a scan runs; the
// scan also stalls while a finished entry waits in the output register and another one is
// ready behind it. Each entry is held back by one so that the final one of a row can carry
// last_of_run. The user must write text_length through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block itself does not enforce this.
module suffixient_set_scan_top
	import sss_pkg::*;
#(
	parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
	parameter int POS_BITS = DEF_POS_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [WORD_W-1:0] cfg_wr_data,
	sss_chan_if.sink          rows,
	sss_chan_if.source        entries
);

	// Characters with candidate slots; the scan covers 1 and up, and the rest never flush or emit
	localparam int SLOT_N = (ALPHABET_SIZE < CHAR_N) ? ALPHABET_SIZE : CHAR_N;
	localparam int SLOT_W = (SLOT_N > 1) ? $clog2(SLOT_N) : 1;
	localparam int N_W = $clog2(MAX_RESULTS + 1);
	localparam logic [SLOT_W-1:0] IDX_FIRST = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(SLOT_N - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REFRESH,
		S_FINISH
	} state_t;

	state_t state_q;

	// Config register
	logic [WORD_W-1:0] text_len_q;

	// Candidates, lengths and lcs stored as value plus one (-1 becomes 0)
	logic [LEN_W-1:0]    len1_q   [SLOT_N];
	logic [POS_BITS-1:0] pos_q    [SLOT_N];
	logic [LEN_W-1:0]    lcs1_q   [SLOT_N];
	logic                active_q [SLOT_N];

	// Previous entry per character
	logic              pvalid_q [SLOT_N];
	logic [WORD_W-1:0] pindex_q [SLOT_N];
	logic [WORD_W-1:0] plcs_q   [SLOT_N];

	// Running state across rows
	logic [WORD_W-1:0] min_q;
	logic              min_inf_q;
	logic [CHAR_W-1:0] prev_ch_q;
	logic [WORD_W-1:0] prev_sa_q;
	logic              seen_q;
	logic [WORD_W-1:0] entry_cnt_q;

	// Per-row work registers
	logic [WORD_W-1:0] row_sa_q;
	logic [WORD_W-1:0] row_lcp_q;
	logic [CHAR_W-1:0] row_ch_q;
	logic              row_last_q;
	logic [CHAR_W-1:0] old_ch_q;
	logic [WORD_W-1:0] old_sa_q;
	logic [LEN_W-1:0]  m1_q;
	logic              final_q;
	logic [SLOT_W-1:0] idx_q;
	logic [N_W-1:0]    n_q;

	// Held-back entry and output register
	entry_t pend_q;
	logic   pend_valid_q;
	entry_t out_q;
	logic   out_valid_q;

	// Handshake and scan control
	logic              accept;
	logic              can_push;
	logic              hit;
	logic              want_emit;
	logic              stall;
	logic              scan_go;
	logic              emit;
	logic              push_scan;
	logic              push_fin;
	logic [WORD_W-1:0] new_min;
	logic [LEN_W-1:0]  lcp1;
	logic [WORD_W-1:0] lcs_cur;
	logic [POS_BITS-1:0] pos_m1;
	entry_t            new_entry;
	entry_t            fin_entry;
	logic              old_in_range;
	logic              cur_in_range;
	logic [SLOT_W-1:0] old_idx;
	logic [SLOT_W-1:0] cur_idx;

	assign rows.ready    = (state_q == S_IDLE);
	assign entries.valid = out_valid_q;
	assign entries.data  = out_q;

	assign accept   = rows.valid & rows.ready;
	assign can_push = ~out_valid_q | entries.ready;

	// Running minimum including the incoming row
	assign new_min = (min_inf_q || (rows.data.lcp < min_q)) ? rows.data.lcp : min_q;

	// Shared compare and entry build for the character under scan
	assign hit       = (m1_q < len1_q[idx_q]);
	assign want_emit = hit & active_q[idx_q] & (n_q < N_W'(MAX_RESULTS));
	assign stall     = want_emit & pend_valid_q & ~can_push;
	assign scan_go   = (state_q == S_SCAN) & ~stall;
	assign emit      = scan_go & want_emit;
	assign push_scan = emit & pend_valid_q;
	assign push_fin  = (state_q == S_FINISH) & pend_valid_q & can_push;

	assign lcs_cur = lcs1_q[idx_q][WORD_W-1:0];
	assign pos_m1  = pos_q[idx_q] - POS_BITS'(1);

	always_comb begin
		new_entry.entry_index   = entry_cnt_q;
		new_entry.text_position = WORD_W'(pos_m1);
		new_entry.lcs_value     = lcs_cur;
		new_entry.entry_char    = CHAR_W'(idx_q);
		new_entry.has_prev      = pvalid_q[idx_q];
		new_entry.prev_index    = pvalid_q[idx_q] ? pindex_q[idx_q] : '0;
		new_entry.prev_lcs      = '0;
		if (pvalid_q[idx_q]) begin
			new_entry.prev_lcs = (plcs_q[idx_q] > lcs_cur) ? plcs_q[idx_q] : lcs_cur;
		end
		new_entry.last_of_run   = 1'b0;
	end

	// Final entry of a row carries the run mark
	always_comb begin
		fin_entry             = pend_q;
		fin_entry.last_of_run = 1'b1;
	end

	// Refresh targets: previous row's character and this row's character
	assign lcp1         = {1'b0, row_lcp_q} + LEN_W'(1);
	assign old_in_range = (int'(old_ch_q) < SLOT_N);
	assign cur_in_range = (int'(row_ch_q) < SLOT_N);
	assign old_idx      = SLOT_W'(old_ch_q);
	assign cur_idx      = SLOT_W'(row_ch_q);

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_len_q <= TEXT_LEN_RESET;
		end else if (cfg_wr_en) begin
			text_len_q <= cfg_wr_data;
		end
	end

	// Sequencer, candidate state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			for (int c = 0; c < SLOT_N; c++) begin
				len1_q[c]   <= '0;
				pos_q[c]    <= '0;
				lcs1_q[c]   <= '0;
				active_q[c] <= 1'b0;
				pvalid_q[c] <= 1'b0;
				pindex_q[c] <= '0;
				plcs_q[c]   <= '0;
			end
			min_q        <= '0;
			min_inf_q    <= 1'b1;
			prev_ch_q    <= '0;
			prev_sa_q    <= '0;
			seen_q       <= 1'b0;
			entry_cnt_q  <= '0;
			old_ch_q     <= '0;
			old_sa_q     <= '0;
			m1_q         <= '0;
			final_q      <= 1'b0;
			idx_q        <= IDX_FIRST;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// Output register: loaded by a push, drained on its own handshake
			if (push_scan || push_fin) begin
				out_valid_q <= 1'b1;
			end else if (entries.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q       <= '0;
						idx_q     <= IDX_FIRST;
						prev_ch_q <= rows.data.bwt_char;
						prev_sa_q <= rows.data.sa_value;
						old_ch_q  <= prev_ch_q;
						old_sa_q  <= prev_sa_q;
						if (seen_q) begin
							min_q     <= new_min;
							min_inf_q <= 1'b0;
							if (rows.data.bwt_char != prev_ch_q) begin
								m1_q    <= {1'b0, new_min} + LEN_W'(1);
								final_q <= 1'b0;
								state_q <= S_SCAN;
							end else if (rows.data.is_last) begin
								m1_q    <= '0;
								final_q <= 1'b1;
								state_q <= S_SCAN;
							end
						end else begin
							seen_q <= 1'b1;
							if (rows.data.is_last) begin
								m1_q    <= '0;
								final_q <= 1'b1;
								state_q <= S_SCAN;
							end
						end
					end
				end

				S_SCAN: begin
					if (scan_go) begin
						if (emit) begin
							pend_valid_q      <= 1'b1;
							pvalid_q[idx_q]   <= 1'b1;
							pindex_q[idx_q]   <= entry_cnt_q;
							plcs_q[idx_q]     <= lcs_cur;
							entry_cnt_q       <= entry_cnt_q + WORD_W'(1);
							n_q               <= n_q + N_W'(1);
						end
						// Flushed candidate takes the running minimum
						if (hit) begin
							len1_q[idx_q]   <= m1_q;
							pos_q[idx_q]    <= '0;
							lcs1_q[idx_q]   <= m1_q;
							active_q[idx_q] <= 1'b0;
						end
						if (idx_q == IDX_LAST) begin
							state_q <= final_q ? S_FINISH : S_REFRESH;
						end else begin
							idx_q <= idx_q + SLOT_W'(1);
						end
					end
				end

				S_REFRESH: begin
					if (old_in_range && (lcp1 > len1_q[old_idx])) begin
						len1_q[old_idx]   <= lcp1;
						pos_q[old_idx]    <= POS_BITS'(text_len_q) - POS_BITS'(old_sa_q);
						active_q[old_idx] <= 1'b1;
					end
					if (cur_in_range && (lcp1 > len1_q[cur_idx])) begin
						len1_q[cur_idx]   <= lcp1;
						pos_q[cur_idx]    <= POS_BITS'(text_len_q) - POS_BITS'(row_sa_q);
						active_q[cur_idx] <= 1'b1;
					end
					min_inf_q <= 1'b1;
					if (row_last_q) begin
						m1_q    <= '0;
						final_q <= 1'b1;
						idx_q   <= IDX_FIRST;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_FINISH;
					end
				end

				S_FINISH: begin
					if (!pend_valid_q || can_push) begin
						if (pend_valid_q) begin
							pend_valid_q <= 1'b0;
						end
						// Restart after the final row
						if (row_last_q) begin
							for (int c = 0; c < SLOT_N; c++) begin
								len1_q[c]   <= '0;
								pos_q[c]    <= '0;
								lcs1_q[c]   <= '0;
								active_q[c] <= 1'b0;
								pvalid_q[c] <= 1'b0;
								pindex_q[c] <= '0;
								plcs_q[c]   <= '0;
							end
							min_q       <= '0;
							min_inf_q   <= 1'b1;
							prev_ch_q   <= '0;
							prev_sa_q   <= '0;
							seen_q      <= 1'b0;
							entry_cnt_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			row_sa_q   <= rows.data.sa_value;
			row_lcp_q  <= rows.data.lcp;
			row_ch_q   <= rows.data.bwt_char;
			row_last_q <= rows.data.is_last;
		end
		if (push_scan) begin
			out_q <= pend_q;
		end
		if (push_fin) begin
			out_q <= fin_entry;
		end
		if (emit) begin
			pend_q <= new_entry;
		end
	end

	// Checks
	a_result_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= N_W'(MAX_RESULTS))
		else $error("more results than allowed for one row");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_valid_q)
		else $error("held-back entry left over when idle");

	a_no_prev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.has_prev) |-> (out_q.prev_index == '0 && out_q.prev_lcs == '0))
		else $error("previous-entry fields set without a previous entry");

	a_last_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rows.data.is_last) |=> (state_q == S_SCAN))
		else $error("final row did not start a flush");

endmodule
